### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lpd_pkg.sv
// Types and constants of the length-prefix message deframer.
package lpd_pkg;

	localparam int unsigned HDR_BYTES = 4;
	localparam logic [31:0] MAX_BODY_LENGTH_RST = 32'd1048576;

	typedef enum logic [1:0] {
		KIND_BODY  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        last;
	} result_t;

endpackage

### rtl/lpd_in_reg.sv
// Input register stage of the deframer.
module lpd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] stream_byte,
	input  logic       advance,
	output logic       in_stall,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import lpd_pkg::*;

	// The stage holds its word only while the result side cannot take it.
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

endmodule

### rtl/lpd_core.sv
// Header assembly, length check, body forwarding and result register.
module lpd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  logic [7:0]      byte_s1,
	input  logic [31:0]     max_len,
	input  logic            out_stall,
	output logic            advance,
	output logic            out_valid,
	output lpd_pkg::result_t result
);
	import lpd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_ERROR  = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic [31:0] len_acc_q, len_acc_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] acc_new;
	logic [31:0] remain_dec;
	logic        emit;
	result_t     res_d;

	assign advance = ~out_valid | ~out_stall;

	always_comb begin
		acc_new    = len_acc_q | ({24'd0, byte_s1} << {hdr_cnt_q, 3'b000});
		remain_dec = (remain_q == 32'd0) ? 32'd0 : remain_q - 32'd1;
		phase_d    = phase_q;
		hdr_cnt_d  = hdr_cnt_q;
		len_acc_d  = len_acc_q;
		remain_d   = remain_q;
		emit       = 1'b0;
		res_d      = '{kind: KIND_BODY, data: 8'd0, last: 1'b0};
		case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q != 2'(HDR_BYTES - 1)) begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
					len_acc_d = acc_new;
				end else begin
					hdr_cnt_d = 2'd0;
					emit      = 1'b1;
					res_d     = '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
					if (acc_new > max_len) begin
						phase_d    = PH_ERROR;
						len_acc_d  = 32'd0;
						remain_d   = 32'd0;
						res_d.kind = KIND_ERROR;
					end else if (acc_new == 32'd0) begin
						len_acc_d = 32'd0;
					end else begin
						// A nonzero length opens the body; no result for this word.
						emit      = 1'b0;
						remain_d  = acc_new;
						len_acc_d = 32'd0;
						phase_d   = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				remain_d = remain_dec;
				emit     = 1'b1;
				res_d    = '{kind: KIND_BODY, data: byte_s1, last: (remain_dec == 32'd0)};
				if (remain_dec == 32'd0) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				// Error is sticky: every word is dropped until reset.
				phase_d = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= 2'd0;
			len_acc_q <= 32'd0;
			remain_q  <= 32'd0;
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 & emit;
			if (valid_s1) begin
				phase_q   <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				len_acc_q <= len_acc_d;
				remain_q  <= remain_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			result <= res_d;
		end
	end

endmodule

### rtl/length_prefix_message_deframer_core.sv
// Top level of the length-prefix message deframer.
// Takes one stream byte per clock: each word passes an input register and the
// header/body decode into a result register, so a result is presented once its
// word has passed both registers, and a new word is taken every cycle unless a
// held result is stalled by out_stall. Each message is a 4-byte little-endian
// length then that many body bytes; body bytes come out one by one with
// message_end on the last, a zero length gives one empty-message result, and
// a length above max_body_length gives one error result after which all input
// is dropped until reset. Write max_body_length only while no word is in
// flight.
`include "assert_macros.svh"

module length_prefix_message_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        max_body_length_wr,
	input  logic [31:0] max_body_length,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  body_byte,
	output logic        message_end
);
	import lpd_pkg::*;

	logic [31:0] max_len_q;
	logic        advance;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	result_t     result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_BODY_LENGTH_RST;
		end else if (max_body_length_wr) begin
			max_len_q <= max_body_length;
		end
	end

	lpd_in_reg u_in_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.stream_byte (stream_byte),
		.advance     (advance),
		.in_stall    (in_stall),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1)
	);

	lpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.max_len   (max_len_q),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.result    (result)
	);

	assign result_kind = result.kind;
	assign body_byte   = result.data;
	assign message_end = result.last;

	`ASSERT_IMPLIES(a_stall_only_when_full, clk, arst_n, in_stall, out_valid && out_stall, "input stalled while result register free")
	`ASSERT_IMPLIES(a_non_body_closes, clk, arst_n, out_valid && result_kind != KIND_BODY, message_end && body_byte == 8'd0, "empty or error result malformed")
	`ASSERT_NEXT(a_error_is_final, clk, arst_n, out_valid && !out_stall && result_kind == KIND_ERROR, !out_valid, "result after length error")

endmodule

### test/tb_top.sv
// Self-checking testbench for the length-prefix message deframer core.
`timescale 1ns / 100ps

module tb_top;
	import lpd_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1900;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned LIMIT_CYCLES = 500000;
	localparam int unsigned MAX_TEST_LEN = 300;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_BODY   = 2'd1,
		PH_ERROR  = 2'd2
	} phase_t;

	typedef enum logic {
		ROW_WORD = 1'b0,
		ROW_CFG  = 1'b1
	} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [31:0] val;
		bit          typed;
		bit          has_res;
		result_t     res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        max_body_length_wr = 1'b0;
	logic [31:0] max_body_length = MAX_BODY_LENGTH_RST;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  stream_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  body_byte;
	logic        message_end;

	length_prefix_message_deframer_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.max_body_length_wr(max_body_length_wr),
		.max_body_length   (max_body_length),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.stream_byte       (stream_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_kind       (result_kind),
		.body_byte         (body_byte),
		.message_end       (message_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow state of the deframer.
	phase_t      ph = PH_HEADER;
	logic [1:0]  hdr_pos = 2'd0;
	logic [31:0] len_acc = 32'd0;
	logic [31:0] remaining = 32'd0;
	logic [31:0] limit_shadow = MAX_BODY_LENGTH_RST;

	result_t     pending_results[$];
	row_t        script[$];
	int unsigned fail_count = 0;
	int unsigned words_sent = 0;
	int unsigned burst_left = 4;
	int unsigned cycles = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;

	// Advances the shadow state by one stream byte; returns 1 when a result is due.
	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		r = '0;
		case (ph)
			PH_HEADER: begin
				len_acc = len_acc | ({24'd0, b} << {hdr_pos, 3'b000});
				if (hdr_pos != 2'd3) begin
					hdr_pos = hdr_pos + 2'd1;
					return 1'b0;
				end
				hdr_pos = 2'd0;
				if (len_acc > limit_shadow) begin
					ph = PH_ERROR;
					len_acc = 32'd0;
					remaining = 32'd0;
					r.kind = KIND_ERROR;
					r.last = 1'b1;
					return 1'b1;
				end
				if (len_acc == 32'd0) begin
					r.kind = KIND_EMPTY;
					r.last = 1'b1;
					return 1'b1;
				end
				remaining = len_acc;
				len_acc = 32'd0;
				ph = PH_BODY;
				return 1'b0;
			end
			PH_BODY: begin
				if (remaining != 32'd0)
					remaining = remaining - 32'd1;
				r.kind = KIND_BODY;
				r.data = b;
				r.last = (remaining == 32'd0);
				if (r.last)
					ph = PH_HEADER;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_word(input logic [7:0] b);
		script.push_back('{ROW_WORD, {24'd0, b}, 1'b0, 1'b0, '0});
	endfunction

	function automatic void add_checked(input logic [7:0] b, input bit has_res,
			input kind_t kind, input logic [7:0] data, input logic last);
		result_t r;
		r.kind = kind;
		r.data = data;
		r.last = last;
		script.push_back('{ROW_WORD, {24'd0, b}, 1'b1, has_res, r});
	endfunction

	function automatic void add_cfg(input logic [31:0] v);
		script.push_back('{ROW_CFG, v, 1'b0, 1'b0, '0});
	endfunction

	// Presents one word, waits for it to be taken, then records what it must produce.
	task automatic send_word(input logic [7:0] b, input bit typed, input bit has_res,
			input result_t fixed_res);
		result_t r;
		bit      got;
		in_valid <= 1'b1;
		stream_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = deframe_byte(b, r);
		if (typed) begin
			if (has_res)
				pending_results.push_back(fixed_res);
		end else if (got) begin
			pending_results.push_back(r);
		end
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(10, 30)) @(posedge clk);
			else
				repeat ($urandom_range(1, 4)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 8);
		end
	endtask

	// Stops the stream and lets every word in flight drain out.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [31:0] v);
		quiesce();
		max_body_length_wr <= 1'b1;
		max_body_length <= v;
		@(posedge clk);
		max_body_length_wr <= 1'b0;
		limit_shadow = v;
	endtask

	task automatic run_row(input row_t row);
		if (row.op == ROW_CFG)
			set_limit(row.val);
		else
			send_word(row.val[7:0], row.typed, row.has_res, row.res);
	endtask

	task automatic send_message(input logic [31:0] len);
		for (int i = 0; i < 4; i++)
			send_word(len[8*i +: 8], 1'b0, 1'b0, '0);
		for (int unsigned i = 0; i < len; i++)
			send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
	endtask

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1;
			2: return $urandom_range(2, 20);
			3: return 32'd255;
			4: return 32'd256;
			5: return MAX_BODY_LENGTH_RST;
			6: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Lengths stay small so that the run stays short; equal-to-limit comes up when it fits.
	function automatic logic [31:0] pick_length(input logic [31:0] lim);
		logic [31:0] cap;
		logic [31:0] short_cap;
		cap = (lim < MAX_TEST_LEN) ? lim : MAX_TEST_LEN;
		short_cap = (cap < 16) ? cap : 16;
		case ($urandom_range(0, 9))
			0, 1: return 32'd0;
			2: return cap;
			3, 4: return $urandom_range(0, cap);
			default: return $urandom_range(0, short_cap);
		endcase
	endfunction

	initial begin
		int unsigned head_rows;
		int unsigned start_words;

		// Zero length under the reset limit.
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'h00, 1'b1, KIND_EMPTY, 8'h00, 1'b1);
		// One-byte body, then a two-byte body.
		add_word(8'h01); add_word(8'h00); add_word(8'h00); add_word(8'h00);
		add_checked(8'hFF, 1'b1, KIND_BODY, 8'hFF, 1'b1);
		add_word(8'h02); add_word(8'h00); add_word(8'h00); add_word(8'h00);
		add_word(8'h00); add_word(8'h80);
		// A length equal to the limit is accepted.
		add_cfg(32'd2);
		add_word(8'h02); add_word(8'h00); add_word(8'h00); add_word(8'h00);
		add_word(8'h5A); add_word(8'hA5);
		add_cfg(32'd0);
		add_word(8'h00); add_word(8'h00); add_word(8'h00);
		add_checked(8'h00, 1'b1, KIND_EMPTY, 8'h00, 1'b1);
		add_cfg(32'hFFFF_FFFF);
		add_word(8'h01); add_word(8'h00); add_word(8'h00); add_word(8'h00);
		add_word(8'h7F);
		head_rows = script.size();
		// The oversize error is sticky, so it closes the run: error, then dropped words.
		add_cfg(32'hFFFF_FFFE);
		add_checked(8'hFF, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'hFF, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'hFF, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'hFF, 1'b1, KIND_ERROR, 8'h00, 1'b1);
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'hA5, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);
		add_checked(8'h00, 1'b0, KIND_BODY, 8'h00, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < head_rows; i++)
			run_row(script[i]);

		start_words = words_sent;
		while (words_sent - start_words < RANDOM_WORDS) begin
			set_limit(pick_limit());
			repeat ($urandom_range(4, 20))
				if (words_sent - start_words < RANDOM_WORDS)
					send_message(pick_length(limit_shadow));
		end

		for (int unsigned i = head_rows; i < script.size(); i++)
			run_row(script[i]);

		quiesce();
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// The receiver switches between stall patterns every so often.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (cycles % 3 == 0);
		endcase
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: result_kind=%0d body_byte=%0h message_end=%0b",
					result_kind, body_byte, message_end);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
					fail_count++;
				end
				if (body_byte !== want.data) begin
					$error("body_byte: expected %0h, actual %0h", want.data, body_byte);
					fail_count++;
				end
				if (message_end !== want.last) begin
					$error("message_end: expected %0b, actual %0b", want.last, message_end);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

endmodule

### sim.f
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_in_reg.sv
rtl/lpd_core.sv
rtl/length_prefix_message_deframer_core.sv
test/tb_top.sv
